### rtl/pms_pkg.sv
// Shared types for the point median selector: controller commands and datapath status.
`default_nettype none
package pms_pkg;

	// Memory read address source
	typedef enum logic [2:0] {
		RS_X, RS_Y, RS_INEXT, RS_JPREV, RS_J, RS_L1, RS_POS, RS_MED
	} rd_sel_t;

	// Memory write address source
	typedef enum logic [2:0] {
		WS_CNT, WS_X, WS_Y, WS_L1, WS_J
	} wr_sel_t;

	// Memory write data source
	typedef enum logic [1:0] {
		WD_IN, WD_A, WD_B, WD_PIV
	} wd_sel_t;

	// Position pair for a compare-and-swap (also the step of the pivot setup)
	typedef enum logic [2:0] {
		PR_MID_L1, PR_L_R, PR_L1_R, PR_L_L1, PR_I_J, PR_FIN
	} pair_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		wd_sel_t wd_sel;
		logic    pair_set;
		pair_t   pair;
		logic    cap_a;
		logic    cap_b;
		logic    cap_piv;
		logic    sel_init;
		logic    ij_init;
		logic    i_inc;
		logic    j_dec;
		logic    bounds_upd;
		logic    load_acc;
		logic    read_acc;
		logic    out_med;
		logic    out_rd;
	} pms_cmd_t;

	typedef struct packed {
		logic ab_gt;
		logic cur_lt_piv;
		logic cur_gt_piv;
		logic span_done;
		logic span_pair;
		logic j_lt_i;
		logic out_busy;
	} pms_stat_t;

endpackage
`default_nettype wire

### rtl/pms_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module pms_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/pms_datapath.sv
// Datapath: point store, index registers, composite comparator and result register.
`default_nettype none
module pms_datapath import pms_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int NUM_AXES   = 3,
	parameter int COORD_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pms_cmd_t           cmd,
	output pms_stat_t               stat,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_wr_data,
	input  wire logic signed [31:0] coord_a,
	input  wire logic signed [31:0] coord_b,
	input  wire logic signed [31:0] coord_c,
	input  wire logic               final_point,
	input  wire logic [9:0]         read_position,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic                    result_kind,
	output logic signed [31:0]      out_a,
	output logic signed [31:0]      out_b,
	output logic signed [31:0]      out_c,
	output logic                    overflow_flag
);

	localparam int KB  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int PTW = 3 * KB;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int PW  = (CW > 10) ? CW : 10;

	logic [1:0]     split_q;
	logic [CW-1:0]  cnt_q;
	logic           drop_q, closed_q, rd_ok_q;
	logic [AW-1:0]  l_q, r_q, i_q, j_q, x_q, y_q, tgt_q;
	logic [PTW-1:0] a_q, b_q, piv_q, res_q;
	logic           out_valid_q, kind_q, flag_q;

	logic [CW-1:0]  eff_cnt;
	logic           full, pos_ok, ram_we;
	logic [AW-1:0]  l1, mid, raddr, waddr;
	logic [AW:0]    sum_lr;
	logic [PTW-1:0] wdata, rdata;
	logic [1:0]     ax0, cmp_ab, cmp_cur;

	// Signed compare on the split axis, then the other axes in descending cyclic order
	function automatic logic [1:0] cmp_pt(input logic [PTW-1:0] p, input logic [PTW-1:0] q,
		input logic [1:0] first_ax);
		logic [1:0] ax;
		logic gt, lt, hit;
		logic signed [KB-1:0] x, y;
		int n;
		ax  = first_ax;
		gt  = 1'b0;
		lt  = 1'b0;
		hit = 1'b0;
		for (n = 0; n < NUM_AXES; n++) begin
			case (ax)
				2'd0: begin
					x = p[KB-1:0];
					y = q[KB-1:0];
				end
				2'd1: begin
					x = p[2*KB-1:KB];
					y = q[2*KB-1:KB];
				end
				default: begin
					x = p[3*KB-1:2*KB];
					y = q[3*KB-1:2*KB];
				end
			endcase
			if (!hit) begin
				if (x > y) begin
					gt  = 1'b1;
					hit = 1'b1;
				end else if (x < y) begin
					lt  = 1'b1;
					hit = 1'b1;
				end
			end
			ax = (ax == 2'd0) ? 2'(NUM_AXES - 1) : ax - 2'd1;
		end
		return {gt, lt};
	endfunction

	// Address and data selection
	assign eff_cnt = closed_q ? '0 : cnt_q;
	assign full    = (eff_cnt == CW'(MAX_POINTS));
	assign l1      = l_q + 1'b1;
	assign sum_lr  = {1'b0, l_q} + {1'b0, r_q};
	assign mid     = sum_lr[AW:1];
	assign pos_ok  = PW'(read_position) < PW'(cnt_q);
	assign ax0     = (int'(split_q) >= NUM_AXES) ? 2'(NUM_AXES - 1) : split_q;

	always_comb begin
		case (cmd.rd_sel)
			RS_X:     raddr = x_q;
			RS_Y:     raddr = y_q;
			RS_INEXT: raddr = i_q + 1'b1;
			RS_JPREV: raddr = j_q - 1'b1;
			RS_J:     raddr = j_q;
			RS_L1:    raddr = l1;
			RS_POS:   raddr = AW'(read_position);
			RS_MED:   raddr = tgt_q;
			default:  raddr = x_q;
		endcase
		case (cmd.wr_sel)
			WS_CNT:  waddr = eff_cnt[AW-1:0];
			WS_X:    waddr = x_q;
			WS_Y:    waddr = y_q;
			WS_L1:   waddr = l1;
			WS_J:    waddr = j_q;
			default: waddr = x_q;
		endcase
		case (cmd.wd_sel)
			WD_IN:   wdata = {coord_c[KB-1:0], coord_b[KB-1:0], coord_a[KB-1:0]};
			WD_A:    wdata = a_q;
			WD_B:    wdata = b_q;
			WD_PIV:  wdata = piv_q;
			default: wdata = a_q;
		endcase
	end

	// A load into a full store is dropped
	assign ram_we = cmd.wr_en && !(cmd.wr_sel == WS_CNT && full);

	pms_ram #(
		.WIDTH(PTW),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Status back to the controller
	assign cmp_ab  = cmp_pt(a_q, b_q, ax0);
	assign cmp_cur = cmp_pt(rdata, piv_q, ax0);
	always_comb begin
		stat.ab_gt      = cmp_ab[1];
		stat.cur_gt_piv = cmp_cur[1];
		stat.cur_lt_piv = cmp_cur[0];
		stat.span_done  = {1'b0, r_q} <= ({1'b0, l_q} + 1'b1);
		stat.span_pair  = {1'b0, r_q} == ({1'b0, l_q} + 1'b1);
		stat.j_lt_i     = j_q < i_q;
		stat.out_busy   = out_valid_q;
	end

	// Control state: split axis, count, flags, bounds, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q     <= '0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			closed_q    <= 1'b0;
			l_q         <= '0;
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				split_q <= cfg_wr_data;
			end
			if (cmd.load_acc) begin
				cnt_q    <= full ? eff_cnt : eff_cnt + 1'b1;
				drop_q   <= (drop_q && !closed_q) || full;
				closed_q <= final_point;
			end
			if (cmd.sel_init) begin
				l_q <= '0;
				r_q <= AW'(cnt_q - 1'b1);
			end
			if (cmd.bounds_upd) begin
				if (j_q >= tgt_q) begin
					r_q <= j_q - 1'b1;
				end
				if (j_q <= tgt_q) begin
					l_q <= i_q;
				end
			end
			if (cmd.out_med || cmd.out_rd) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.sel_init) begin
			tgt_q <= AW'(cnt_q >> 1);
		end
		if (cmd.pair_set) begin
			case (cmd.pair)
				PR_MID_L1: begin
					x_q <= mid;
					y_q <= l1;
				end
				PR_L1_R: begin
					x_q <= l1;
					y_q <= r_q;
				end
				PR_L_L1: begin
					x_q <= l_q;
					y_q <= l1;
				end
				PR_I_J: begin
					x_q <= i_q;
					y_q <= j_q;
				end
				default: begin
					x_q <= l_q;
					y_q <= r_q;
				end
			endcase
		end
		if (cmd.ij_init) begin
			i_q <= l1;
			j_q <= r_q;
		end
		if (cmd.i_inc) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.j_dec) begin
			j_q <= j_q - 1'b1;
		end
		if (cmd.cap_a) begin
			a_q <= rdata;
		end
		if (cmd.cap_b) begin
			b_q <= rdata;
		end
		if (cmd.cap_piv) begin
			piv_q <= rdata;
		end
		if (cmd.read_acc) begin
			rd_ok_q <= pos_ok;
		end
		if (cmd.out_med) begin
			kind_q <= 1'b0;
			res_q  <= rdata;
			flag_q <= drop_q;
		end
		if (cmd.out_rd) begin
			kind_q <= 1'b1;
			res_q  <= rd_ok_q ? rdata : '0;
			flag_q <= !rd_ok_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign overflow_flag = flag_q;
	assign out_a         = 32'($signed(res_q[KB-1:0]));
	assign out_b         = 32'($signed(res_q[2*KB-1:KB]));
	assign out_c         = 32'($signed(res_q[3*KB-1:2*KB]));

endmodule
`default_nettype wire

### rtl/pms_ctrl.sv
// Controller: request intake and the quickselect sequencer.
`default_nettype none
module pms_ctrl import pms_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      action,
	input  wire logic      final_point,
	input  wire pms_stat_t stat,
	output logic           in_stall,
	output pms_cmd_t       cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_WAIT, ST_SEL_INIT, ST_SEL_LOOP,
		ST_CS_RX, ST_CS_RY, ST_CS_CB, ST_CS_WX, ST_CS_WY,
		ST_PIV_RD, ST_PIV_CAP, ST_SCAN_I, ST_I_CHK, ST_SCAN_J, ST_J_CHK,
		ST_BRK_RD, ST_BRK_CAP, ST_BRK_W1, ST_BRK_W2, ST_MED_RD, ST_MED_OUT
	} state_t;

	state_t state_q;
	pair_t  ph_q;
	logic   accept, force_swap;
	state_t cs_ret;
	pair_t  cs_next;

	assign in_stall   = (state_q != ST_IDLE) || stat.out_busy;
	assign accept     = in_valid && !in_stall;
	assign force_swap = (ph_q == PR_MID_L1) || (ph_q == PR_I_J);

	// Where a compare-and-swap returns to, and the next setup pair
	always_comb begin
		cs_next = PR_L_R;
		case (ph_q)
			PR_MID_L1: begin
				cs_ret  = ST_CS_RX;
				cs_next = PR_L_R;
			end
			PR_L_R: begin
				cs_ret  = ST_CS_RX;
				cs_next = PR_L1_R;
			end
			PR_L1_R: begin
				cs_ret  = ST_CS_RX;
				cs_next = PR_L_L1;
			end
			PR_L_L1: cs_ret = ST_PIV_RD;
			PR_I_J:  cs_ret = ST_SCAN_I;
			PR_FIN:  cs_ret = ST_MED_RD;
			default: cs_ret = ST_MED_RD;
		endcase
	end

	// Command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && action) begin
					cmd.read_acc = 1'b1;
					cmd.rd_sel   = RS_POS;
				end else if (accept) begin
					cmd.load_acc = 1'b1;
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WS_CNT;
					cmd.wd_sel   = WD_IN;
				end
			end
			ST_RD_WAIT:  cmd.out_rd = 1'b1;
			ST_SEL_INIT: cmd.sel_init = 1'b1;
			ST_SEL_LOOP: begin
				cmd.pair_set = 1'b1;
				cmd.pair     = stat.span_done ? PR_FIN : PR_MID_L1;
			end
			ST_CS_RX: cmd.rd_sel = RS_X;
			ST_CS_RY: begin
				cmd.cap_a  = 1'b1;
				cmd.rd_sel = RS_Y;
			end
			ST_CS_CB: cmd.cap_b = 1'b1;
			ST_CS_WX: begin
				cmd.wr_en  = force_swap || stat.ab_gt;
				cmd.wr_sel = WS_X;
				cmd.wd_sel = WD_B;
			end
			ST_CS_WY: begin
				cmd.wr_en    = force_swap || stat.ab_gt;
				cmd.wr_sel   = WS_Y;
				cmd.wd_sel   = WD_A;
				cmd.pair_set = 1'b1;
				cmd.pair     = cs_next;
			end
			ST_PIV_RD: begin
				cmd.ij_init = 1'b1;
				cmd.rd_sel  = RS_L1;
			end
			ST_PIV_CAP: cmd.cap_piv = 1'b1;
			ST_SCAN_I: begin
				cmd.i_inc  = 1'b1;
				cmd.rd_sel = RS_INEXT;
			end
			ST_SCAN_J: begin
				cmd.j_dec  = 1'b1;
				cmd.rd_sel = RS_JPREV;
			end
			ST_J_CHK: begin
				cmd.pair_set = 1'b1;
				cmd.pair     = PR_I_J;
			end
			ST_BRK_RD:  cmd.rd_sel = RS_J;
			ST_BRK_CAP: cmd.cap_a = 1'b1;
			ST_BRK_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_L1;
				cmd.wd_sel = WD_A;
			end
			ST_BRK_W2: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WS_J;
				cmd.wd_sel     = WD_PIV;
				cmd.bounds_upd = 1'b1;
			end
			ST_MED_RD:  cmd.rd_sel = RS_MED;
			ST_MED_OUT: cmd.out_med = 1'b1;
			default:    cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PR_MID_L1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && action) begin
						state_q <= ST_RD_WAIT;
					end else if (accept && final_point) begin
						state_q <= ST_SEL_INIT;
					end
				end
				ST_RD_WAIT:  state_q <= ST_IDLE;
				ST_SEL_INIT: state_q <= ST_SEL_LOOP;
				ST_SEL_LOOP: begin
					if (stat.span_done && !stat.span_pair) begin
						state_q <= ST_MED_RD;
					end else begin
						state_q <= ST_CS_RX;
						ph_q    <= stat.span_done ? PR_FIN : PR_MID_L1;
					end
				end
				ST_CS_RX: state_q <= ST_CS_RY;
				ST_CS_RY: state_q <= ST_CS_CB;
				ST_CS_CB: state_q <= ST_CS_WX;
				ST_CS_WX: state_q <= ST_CS_WY;
				ST_CS_WY: begin
					// both writes are suppressed when the pair stays in order, but the mid/l+1 and i/j pairs always swap
					state_q <= cs_ret;
					if (cs_ret == ST_CS_RX) begin
						ph_q <= cs_next;
					end
				end
				ST_PIV_RD:  state_q <= ST_PIV_CAP;
				ST_PIV_CAP: state_q <= ST_SCAN_I;
				ST_SCAN_I:  state_q <= ST_I_CHK;
				ST_I_CHK:   state_q <= stat.cur_lt_piv ? ST_SCAN_I : ST_SCAN_J;
				ST_SCAN_J:  state_q <= ST_J_CHK;
				ST_J_CHK: begin
					if (stat.cur_gt_piv) begin
						state_q <= ST_SCAN_J;
					end else if (stat.j_lt_i) begin
						state_q <= ST_BRK_RD;
					end else begin
						state_q <= ST_CS_RX;
						ph_q    <= PR_I_J;
					end
				end
				ST_BRK_RD:  state_q <= ST_BRK_CAP;
				ST_BRK_CAP: state_q <= ST_BRK_W1;
				ST_BRK_W1:  state_q <= ST_BRK_W2;
				ST_BRK_W2:  state_q <= ST_SEL_LOOP;
				ST_MED_RD:  state_q <= ST_MED_OUT;
				ST_MED_OUT: state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/point_median_select.sv
// Top level of the point median selector.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | input     | in_valid / in_stall | action, coord_a/b/c, final_point, read_position
//  out     | output    | out_valid/out_stall | result_kind, out_a/b/c, overflow_flag
//  cfg     | input     | cfg_wr_en           | cfg_wr_data (split_axis)
//
// A load is written to the store when accepted; a read-back reads the store, then registers
// its result. A final load runs quickselect on the single store: each compare-and-swap
// reads x, reads y, captures both, then writes x and y; each scanned element is read, then checked.
// Reset clears count, flags and axis; store contents are not cleared.
// in_stall is high while the controller is not idle (read-back or selecting) or while a result is valid.
`default_nettype none
module point_median_select import pms_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int NUM_AXES   = 3,
	parameter int COORD_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic signed [31:0] coord_a,
	input  wire logic signed [31:0] coord_b,
	input  wire logic signed [31:0] coord_c,
	input  wire logic               final_point,
	input  wire logic [9:0]         read_position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    result_kind,
	output logic signed [31:0]      out_a,
	output logic signed [31:0]      out_b,
	output logic signed [31:0]      out_c,
	output logic                    overflow_flag
);

	pms_cmd_t  cmd;
	pms_stat_t stat;

	pms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.action     (action),
		.final_point(final_point),
		.stat       (stat),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	pms_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.NUM_AXES  (NUM_AXES),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.coord_a      (coord_a),
		.coord_b      (coord_b),
		.coord_c      (coord_c),
		.final_point  (final_point),
		.read_position(read_position),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.out_a        (out_a),
		.out_b        (out_b),
		.out_c        (out_c),
		.overflow_flag(overflow_flag)
	);

endmodule
`default_nettype wire

### rtl/pms_checker.sv
// Port-level checks for the point median selector, bound to the top level.
`default_nettype none
module pms_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               action,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               result_kind,
	input wire logic signed [31:0] out_a,
	input wire logic signed [31:0] out_b,
	input wire logic signed [31:0] out_c,
	input wire logic               overflow_flag
);

	// A stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_a) && $stable(out_b) && $stable(out_c))
		else $error("stalled result changed");

	// No request is taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	// An accepted read-back request yields a valid read-back result
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action |=> ##1 (out_valid && result_kind))
		else $error("read-back result missing");

	// Out-of-range reads return zeros
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind && overflow_flag |-> out_a == 0 && out_b == 0 && out_c == 0)
		else $error("out-of-range read not zero");

endmodule

bind point_median_select pms_checker u_pms_checker (.*);
`default_nettype wire
